### rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DEF_TEXT_ROWS = 40;
    localparam int DEF_TEXT_COLS = 60;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] RETURN_CODE  = 8'd13;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    typedef enum logic [1:0] {
        REQ_PUT_CHAR   = 2'd0,
        REQ_CLEAR      = 2'd1,
        REQ_SET_CURSOR = 2'd2,
        REQ_READ_CELL  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCROLL_PRIME,
        S_SCROLL,
        S_FILL,
        S_PUT,
        S_READ,
        S_READ_CAP,
        S_OUT
    } t_state;

endpackage

### rtl/text_console_writer.sv
// Text console writer: character store, cursor, scroll and serial echo sequencer.
// A scroll walks the store one cell a cycle.
// Clear sweeps the store one cell a cycle, then returns a result.
// Requests: one at a time; a new one is accepted only once the last result has been taken.
// Reset: synchronous, active low; a clearing pass over the whole store follows it.
`timescale 1ns / 1ps

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int TEXT_ROWS = DEF_TEXT_ROWS,
    parameter int TEXT_COLS = DEF_TEXT_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_row_sel,
    input  logic [5:0] i_col_sel,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_serial_byte,
    output logic       o_serial_valid,
    output logic [7:0] o_cell_char,
    output logic [5:0] o_cursor_row_now,
    output logic [5:0] o_cursor_col_now,
    output logic       o_last
);

    localparam int DEPTH = TEXT_ROWS * TEXT_COLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);
    localparam logic [AW-1:0] SCROLL_END  = AW'((TEXT_ROWS - 1) * TEXT_COLS - 1);
    localparam logic [AW-1:0] ROW_STRIDE  = AW'(TEXT_COLS);
    localparam logic [AW-1:0] SRC_STRIDE  = AW'(TEXT_COLS + 1);
    localparam logic [5:0]    LAST_ROW    = 6'(TEXT_ROWS - 1);
    localparam logic [5:0]    LAST_COL    = 6'(TEXT_COLS - 1);
    localparam logic [5:0]    SECOND_LAST = 6'(TEXT_ROWS - 2);

    // Character store: one write port, one registered read port.
    logic [7:0] r_store [DEPTH];
    logic [7:0] r_rd_data;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_store[mem_raddr];
    end

    // Control and payload registers.
    t_state        r_state,     n_state;
    logic [AW-1:0] r_addr,      n_addr;
    logic          r_clr_resp,  n_clr_resp;
    logic [5:0]    r_cur_row,   n_cur_row;
    logic [5:0]    r_cur_col,   n_cur_col;
    logic [7:0]    r_char,      n_char;
    logic [5:0]    r_sel_row,   n_sel_row;
    logic [5:0]    r_sel_col,   n_sel_col;
    logic [7:0]    r_ser_byte,  n_ser_byte;
    logic          r_ser_valid, n_ser_valid;
    logic [7:0]    r_cell,      n_cell;
    logic          r_last,      n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_clr_resp <= 1'b0;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_clr_resp <= n_clr_resp;
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char      <= n_char;
        r_sel_row   <= n_sel_row;
        r_sel_col   <= n_sel_col;
        r_ser_byte  <= n_ser_byte;
        r_ser_valid <= n_ser_valid;
        r_cell      <= n_cell;
        r_last      <= n_last;
    end

    // Shared address unit: row * TEXT_COLS + column, for the cursor or a selection.
    logic          use_sel;
    logic [5:0]    calc_row;
    logic [5:0]    calc_col;
    logic [AW-1:0] calc_addr;
    logic [AW-1:0] addr_inc;

    assign use_sel   = (r_state == S_READ);
    assign calc_row  = use_sel ? r_sel_row : r_cur_row;
    assign calc_col  = use_sel ? r_sel_col : r_cur_col;
    assign calc_addr = AW'(int'(calc_row) * TEXT_COLS + int'(calc_col));
    assign addr_inc  = r_addr + AW'(1);

    // Clamp selections to the last row and column.
    logic [5:0] clamp_row;
    logic [5:0] clamp_col;

    assign clamp_row = (int'(i_row_sel) >= TEXT_ROWS) ? LAST_ROW : i_row_sel;
    assign clamp_col = (int'(i_col_sel) >= TEXT_COLS) ? LAST_COL : i_col_sel;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_clr_resp  = r_clr_resp;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_char      = r_char;
        n_sel_row   = r_sel_row;
        n_sel_col   = r_sel_col;
        n_ser_byte  = r_ser_byte;
        n_ser_valid = r_ser_valid;
        n_cell      = r_cell;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        mem_raddr   = r_addr;

        case (r_state)
            // Zero the store one cell a cycle; after reset no result follows.
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_addr    = addr_inc;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = r_clr_resp ? S_OUT : S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_char      = i_char_code;
                    n_sel_row   = clamp_row;
                    n_sel_col   = clamp_col;
                    n_ser_byte  = '0;
                    n_ser_valid = 1'b0;
                    n_cell      = '0;
                    n_last      = 1'b1;
                    n_addr      = '0;
                    case (t_req'(i_req_type))
                        REQ_PUT_CHAR: begin
                            n_ser_valid = 1'b1;
                            if (i_char_code == NEWLINE_CODE) begin
                                // Echo CR first, then LF; cursor moves before both.
                                n_ser_byte = RETURN_CODE;
                                n_last     = 1'b0;
                                n_cur_col  = '0;
                                if (r_cur_row >= LAST_ROW) begin
                                    n_state = S_SCROLL_PRIME;
                                end else begin
                                    n_cur_row = r_cur_row + 6'd1;
                                    n_state   = S_OUT;
                                end
                            end else begin
                                n_ser_byte = i_char_code;
                                if (r_cur_row >= LAST_ROW && r_cur_col >= LAST_COL) begin
                                    // Bottom-right cell: scroll, then write on the row above.
                                    n_cur_row = SECOND_LAST;
                                    n_state   = S_SCROLL_PRIME;
                                end else begin
                                    n_state = S_PUT;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            n_cur_row  = '0;
                            n_cur_col  = '0;
                            n_clr_resp = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        REQ_SET_CURSOR: begin
                            n_cur_row = clamp_row;
                            n_cur_col = clamp_col;
                            n_state   = S_OUT;
                        end
                        REQ_READ_CELL: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Fetch the first cell of row one.
            S_SCROLL_PRIME: begin
                mem_raddr = ROW_STRIDE;
                n_state   = S_SCROLL;
            end

            // Copy each cell one row up while fetching the next source cell.
            S_SCROLL: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data;
                mem_raddr = r_addr + SRC_STRIDE;
                n_addr    = addr_inc;
                if (r_addr == SCROLL_END) begin
                    n_state = S_FILL;
                end
            end

            // Fill the bottom row with spaces.
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = SPACE_CODE;
                n_addr    = addr_inc;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = (r_char == NEWLINE_CODE) ? S_OUT : S_PUT;
                end
            end

            // Write the character at the cursor and advance it.
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = calc_addr;
                mem_wdata = r_char;
                if (r_cur_col >= LAST_COL) begin
                    n_cur_col = '0;
                    n_cur_row = r_cur_row + 6'd1;
                end else begin
                    n_cur_col = r_cur_col + 6'd1;
                end
                n_state = S_OUT;
            end

            S_READ: begin
                mem_raddr = calc_addr;
                n_state   = S_READ_CAP;
            end

            S_READ_CAP: begin
                n_cell  = r_rd_data;
                n_state = S_OUT;
            end

            // Hold the result until taken; a newline sends LF after CR.
            S_OUT: begin
                if (i_ready) begin
                    if (r_last) begin
                        n_clr_resp = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        n_ser_byte = NEWLINE_CODE;
                        n_last     = 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_serial_byte    = r_ser_byte;
    assign o_serial_valid   = r_ser_valid;
    assign o_cell_char      = r_cell;
    assign o_cursor_row_now = r_cur_row;
    assign o_cursor_col_now = r_cur_col;
    assign o_last           = r_last;

endmodule

### tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: request driver, result monitor, screen predictor.
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int ROWS            = DEF_TEXT_ROWS;
    localparam int COLS            = DEF_TEXT_COLS;
    localparam int RANDOM_REQUESTS = 500;
    // Scroll and clear sweep the whole store one cell a cycle, and reset is followed
    // by a clearing pass of the same length; allow several of those with nothing moving.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int LONG_HOLD       = 300;
    localparam int CALM_TAIL       = 60;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        t_req       kind;
        logic [7:0] char_code;
        logic [5:0] row_sel;
        logic [5:0] col_sel;
    } t_console_request;

    typedef struct packed {
        logic [7:0] serial_byte;
        logic       serial_valid;
        logic [7:0] cell_char;
        logic [5:0] row_now;
        logic [5:0] col_now;
        logic       last;
    } t_console_reply;

    // ---------------------------------------------------------------------
    // Clock, reset and block ports
    // ---------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_req_type = REQ_PUT_CHAR;
    logic [7:0] i_char_code = 8'd0;
    logic [5:0] i_row_sel = 6'd0;
    logic [5:0] i_col_sel = 6'd0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_serial_byte;
    logic       o_serial_valid;
    logic [7:0] o_cell_char;
    logic [5:0] o_cursor_row_now;
    logic [5:0] o_cursor_col_now;
    logic       o_last;

    always #5 i_clk = ~i_clk;

    text_console_writer #(
        .TEXT_ROWS(ROWS),
        .TEXT_COLS(COLS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_char_code     (i_char_code),
        .i_row_sel       (i_row_sel),
        .i_col_sel       (i_col_sel),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_serial_byte   (o_serial_byte),
        .o_serial_valid  (o_serial_valid),
        .o_cell_char     (o_cell_char),
        .o_cursor_row_now(o_cursor_row_now),
        .o_cursor_col_now(o_cursor_col_now),
        .o_last          (o_last)
    );

    // ---------------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------------
    t_console_request console_requests[$];   // requests still to be offered
    t_console_reply   replies_due[$];        // replies predicted, oldest first
    logic [7:0]       screen_cells[ROWS*COLS];
    int               cur_row = 0;
    int               cur_col = 0;

    int unsigned total_requests = 0;
    int unsigned requests_sent = 0;
    int unsigned requests_accepted = 0;
    int unsigned replies_checked = 0;
    int unsigned scroll_count = 0;
    int unsigned clear_count = 0;
    int unsigned error_count = 0;
    int unsigned stalled_cycles = 0;

    logic        hold_active = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_count = 0;

    // ---------------------------------------------------------------------
    // Screen predictor
    // ---------------------------------------------------------------------
    task automatic scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
            screen_cells[i] = screen_cells[i + COLS];
        end
        for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) begin
            screen_cells[i] = SPACE_CODE;
        end
        scroll_count++;
    endtask

    // Every reply carries the cursor as it stands after the whole request.
    task automatic queue_reply(input logic [7:0] sbyte, input logic svalid,
                               input logic [7:0] cell_code, input logic lst);
        t_console_reply rep;
        rep.serial_byte  = sbyte;
        rep.serial_valid = svalid;
        rep.cell_char    = cell_code;
        rep.row_now      = 6'(cur_row);
        rep.col_now      = 6'(cur_col);
        rep.last         = lst;
        replies_due.push_back(rep);
    endtask

    task automatic apply_console_request(input logic [1:0] kind, input logic [7:0] ch,
                                         input logic [5:0] rsel, input logic [5:0] csel);
        int r;
        int c;
        // Clamp out-of-range selections to the last row or column.
        r = (rsel >= ROWS) ? ROWS - 1 : int'(rsel);
        c = (csel >= COLS) ? COLS - 1 : int'(csel);
        case (kind)
            REQ_PUT_CHAR: begin
                if (ch == NEWLINE_CODE) begin
                    // Newline on the bottom row scrolls; otherwise drop one row.
                    if (cur_row >= ROWS - 1) begin
                        scroll_screen();
                        cur_row = ROWS - 1;
                    end else begin
                        cur_row++;
                    end
                    cur_col = 0;
                    queue_reply(RETURN_CODE, 1'b1, 8'd0, 1'b0);
                    queue_reply(NEWLINE_CODE, 1'b1, 8'd0, 1'b1);
                end else begin
                    // Writing into the bottom-right cell scrolls first.
                    if (cur_row >= ROWS - 1 && cur_col >= COLS - 1) begin
                        scroll_screen();
                        cur_row = ROWS - 2;
                    end
                    screen_cells[cur_row * COLS + cur_col] = ch;
                    if (cur_col >= COLS - 1) begin
                        cur_col = 0;
                        cur_row++;
                    end else begin
                        cur_col++;
                    end
                    queue_reply(ch, 1'b1, 8'd0, 1'b1);
                end
            end
            REQ_CLEAR: begin
                foreach (screen_cells[i]) screen_cells[i] = 8'd0;
                cur_row = 0;
                cur_col = 0;
                clear_count++;
                queue_reply(8'd0, 1'b0, 8'd0, 1'b1);
            end
            REQ_SET_CURSOR: begin
                cur_row = r;
                cur_col = c;
                queue_reply(8'd0, 1'b0, 8'd0, 1'b1);
            end
            default: begin
                queue_reply(8'd0, 1'b0, screen_cells[r * COLS + c], 1'b1);
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Reply checking
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_reply();
        t_console_reply want;
        if (replies_due.size() == 0) begin
            $error("unexpected result transaction: serial_byte %0d cell_char %0d",
                   o_serial_byte, o_cell_char);
            error_count++;
        end else begin
            want = replies_due.pop_front();
            check_field("serial_byte", want.serial_byte, o_serial_byte);
            check_field("serial_valid", 8'(want.serial_valid), 8'(o_serial_valid));
            check_field("cell_char", want.cell_char, o_cell_char);
            check_field("cursor_row_now", 8'(want.row_now), 8'(o_cursor_row_now));
            check_field("cursor_col_now", 8'(want.col_now), 8'(o_cursor_col_now));
            check_field("last", 8'(want.last), 8'(o_last));
        end
    endtask

    // Sample both channels at the rising edge. Check the reply before predicting
    // the newly accepted request, since any reply here belongs to an older one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                check_reply();
                replies_checked <= replies_checked + 1;
            end
            if (i_valid && o_ready) begin
                apply_console_request(i_req_type, i_char_code, i_row_sel, i_col_sel);
                requests_accepted <= requests_accepted + 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Idling control
    // ---------------------------------------------------------------------
    // Idle in bursts, except in every fourth window of 50 requests and in the tail.
    function automatic bit idling_allowed();
        return (requests_accepted + CALM_TAIL < total_requests) &&
               ((requests_accepted / 50) % 4 != 3);
    endfunction

    // Request driver: hold the payload until accepted, then advance to the next one.
    int unsigned send_gap = 0;
    always @(negedge i_clk) begin
        t_console_request nxt;
        logic             nxt_valid;
        if (i_rst_n && !(i_valid && requests_sent != requests_accepted)) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (console_requests.size() > 0) begin
                nxt = console_requests.pop_front();
                i_req_type  <= nxt.kind;
                i_char_code <= nxt.char_code;
                i_row_sel   <= nxt.row_sel;
                i_col_sel   <= nxt.col_sel;
                nxt_valid = 1'b1;
                requests_sent++;
                if (idling_allowed() && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 10);
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // Long receiver hold-off once a good number of replies has gone by; the sender
    // keeps offering, so the block fills up and drops its ready.
    always @(posedge i_clk) begin
        if (hold_active) begin
            if (hold_count == LONG_HOLD - 1) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            hold_count <= hold_count + 1;
        end else if (!hold_done && replies_checked >= 150) begin
            hold_active <= 1'b1;
        end
    end

    // Reply receiver: random stall bursts.
    int unsigned ready_stall = 0;
    always @(negedge i_clk) begin
        if (hold_active) begin
            i_ready <= 1'b0;
        end else if (ready_stall > 0) begin
            ready_stall--;
            i_ready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            ready_stall = $urandom_range(1, 10) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic add_request(input t_req kind, input logic [7:0] ch,
                               input logic [5:0] rsel, input logic [5:0] csel);
        t_console_request req;
        req.kind      = kind;
        req.char_code = ch;
        req.row_sel   = rsel;
        req.col_sel   = csel;
        console_requests.push_back(req);
    endtask

    // Rows and columns mostly in range; one in eight spans the whole field.
    function automatic logic [5:0] pick_row();
        return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [5:0] pick_col();
        return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, COLS - 1));
    endfunction

    function automatic logic [7:0] pick_char();
        return ($urandom_range(0, 5) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int unsigned pick;
        int unsigned run_len;
        logic [5:0]  r;
        logic [5:0]  c;

        foreach (screen_cells[i]) screen_cells[i] = 8'd0;

        // Directed: field extremes, every request kind, both scroll triggers,
        // clamping of out-of-range selections, column wrap and clear.
        add_request(REQ_READ_CELL,  8'hFF, 6'd0,  6'd0);
        add_request(REQ_PUT_CHAR,   8'h00, 6'd63, 6'd63);
        add_request(REQ_PUT_CHAR,   8'hFF, 6'd0,  6'd0);
        add_request(REQ_PUT_CHAR,   NEWLINE_CODE, 6'd0, 6'd0);
        add_request(REQ_READ_CELL,  8'h00, 6'd0,  6'd1);
        add_request(REQ_SET_CURSOR, 8'hFF, 6'd63, 6'd63);
        add_request(REQ_PUT_CHAR,   8'h41, 6'd0,  6'd0);
        add_request(REQ_READ_CELL,  8'h00, 6'(ROWS - 1), 6'd0);
        add_request(REQ_READ_CELL,  8'h00, 6'(ROWS - 2), 6'(COLS - 1));
        add_request(REQ_SET_CURSOR, 8'h00, 6'(ROWS - 1), 6'd5);
        add_request(REQ_PUT_CHAR,   NEWLINE_CODE, 6'd0, 6'd0);
        add_request(REQ_READ_CELL,  8'h00, 6'd63, 6'd63);
        add_request(REQ_SET_CURSOR, 8'h00, 6'(ROWS), 6'(COLS));
        add_request(REQ_SET_CURSOR, 8'h00, 6'd0,  6'(COLS - 1));
        add_request(REQ_PUT_CHAR,   8'h7A, 6'd0,  6'd0);
        add_request(REQ_READ_CELL,  8'h00, 6'd0,  6'(COLS - 1));
        add_request(REQ_CLEAR,      8'hFF, 6'd63, 6'd63);
        add_request(REQ_READ_CELL,  8'h00, 6'(ROWS - 2), 6'(COLS - 1));
        add_request(REQ_SET_CURSOR, 8'h00, 6'(ROWS - 1), 6'(COLS - 2));
        add_request(REQ_PUT_CHAR,   8'h71, 6'd0,  6'd0);
        add_request(REQ_PUT_CHAR,   8'h72, 6'd0,  6'd0);
        add_request(REQ_READ_CELL,  8'h00, 6'(ROWS - 2), 6'(COLS - 2));
        add_request(REQ_READ_CELL,  8'h00, 6'(ROWS - 1), 6'd63);

        // Random: mostly text runs (place cursor, type, read back), plus loose requests.
        while (console_requests.size() < RANDOM_REQUESTS + 23) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r = pick_row();
                c = pick_col();
                add_request(REQ_SET_CURSOR, 8'($urandom_range(0, 255)), r, c);
                run_len = $urandom_range(1, 8);
                repeat (run_len) begin
                    add_request(REQ_PUT_CHAR, pick_char(), 6'($urandom_range(0, 63)),
                                6'($urandom_range(0, 63)));
                end
                add_request(REQ_READ_CELL, 8'($urandom_range(0, 255)), r, c);
            end else if (pick < 75) begin
                add_request(REQ_PUT_CHAR, pick_char(), 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)));
            end else if (pick < 85) begin
                add_request(REQ_SET_CURSOR, 8'($urandom_range(0, 255)),
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end else if (pick < 98) begin
                add_request(REQ_READ_CELL, 8'($urandom_range(0, 255)),
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end else begin
                add_request(REQ_CLEAR, 8'($urandom_range(0, 255)),
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end
        end
        total_requests = console_requests.size();

        // Hold reset, then release it away from the sampling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every request to go in and every reply to come back, then drain.
        do @(negedge i_clk);
        while (requests_accepted != total_requests || replies_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d console requests and %0d reply transactions,",
                 requests_accepted, replies_checked);
        $display("including %0d scrolls, %0d clears and a long receiver hold-off.",
                 scroll_count, clear_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/tcw_pkg.sv
rtl/text_console_writer.sv
tb/tb_text_console_writer.sv
